// File: hw/rtl/deq_pkg.sv
// shared types and codes for the double-ended queue core
// no dependencies; imported by deq_out_fifo and double_ended_queue_core
package deq_pkg;

  // operation codes carried on the input tuser
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_DEL_FRONT = 3'd1;
  localparam logic [2:0] OP_INS_REAR  = 3'd2;
  localparam logic [2:0] OP_DEL_REAR  = 3'd3;
  localparam logic [2:0] OP_LIST      = 3'd4;

  // status codes carried on the output tuser
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // result buffer sizing
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef logic signed [31:0] entry_t;

  // one result word
  typedef struct packed {
    entry_t     entry;
    logic [1:0] status;
    logic       is_last;
  } result_t;

  // push request from the control logic into the result buffer
  typedef struct packed {
    logic    valid;
    result_t data;
  } result_push_t;

  // control state
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

endpackage

// File: hw/rtl/deq_out_fifo.sv
// small result buffer between the queue control and the output stream
// depends on deq_pkg for result_t, result_push_t and buffer sizing
module deq_out_fifo import deq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  result_push_t        push,
  output logic [OUT_CW-1:0]   count,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_data
);

  result_t             buf_q [OUT_DEPTH];
  logic [OUT_PW-1:0]   head;
  logic [OUT_PW-1:0]   tail;
  logic                pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = buf_q[head];

  // payload storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      buf_q[tail] <= push.data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        tail <= (tail == OUT_PW'(OUT_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == OUT_PW'(OUT_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (count < OUT_CW'(OUT_DEPTH)))
    else $error("result pushed into full buffer");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> (count == $past(count) + 1'b1))
    else $error("buffer count did not rise on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.valid) |=> (count == $past(count) - 1'b1))
    else $error("buffer count did not fall on pop");
`endif

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// double-ended queue core: ring store in a synchronous memory plus control
// depends on deq_pkg and instantiates deq_out_fifo
//
// A bounded double-ended queue of DEPTH signed 32-bit entries held in a ring
// in one synchronous memory (one write port, one registered read port).
// Each input word carries an operation in tuser and a value in tdata. An
// insert, a delete or an unused op code is handled as it is taken; inserts and
// deletes give a single status word, unused codes give nothing. A list of
// n entries holds off new input while it walks: it is taken, then one memory
// read per cycle from front to rear while the result buffer has room, with
// tlast on the rear entry, and input waits until the last read lands; a list
// of an empty queue gives one empty status word and is handled as it is taken.
// Results pass through a four-word buffer, so the block keeps working while
// the output side stalls until that buffer fills. No clearing pass follows
// reset; the queue is empty at once.
module double_ended_queue_core import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [2:0]  s_axis_tuser,  // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] entry
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast   // is_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] TOP_IDX = IW'(DEPTH - 1);
  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);

  state_t              state, state_next;
  logic [IW-1:0]       front_index, front_index_next;
  logic [CW-1:0]       occupancy, occupancy_next;
  logic [IW-1:0]       rd_addr, rd_addr_next;
  logic [CW-1:0]       lst_left, lst_left_next;

  entry_t              mem [DEPTH];
  entry_t              rd_data;
  logic                rd_pend;
  logic                rd_last;
  logic                rd_issue;

  logic                mem_we;
  logic [IW-1:0]       wr_addr;

  logic                accept;
  logic                room;
  logic                is_full;
  logic                is_empty;
  logic [IW-1:0]       front_dec;
  logic [IW-1:0]       front_inc;
  logic [IW:0]         rear_sum;
  logic [IW-1:0]       rear_addr;

  logic                st_push;
  logic [1:0]          st_code;
  result_push_t        push;
  result_t             out_data;
  logic [OUT_CW-1:0]   fifo_count;

  // ring index arithmetic
  assign is_full   = (occupancy == CW'(DEPTH));
  assign is_empty  = (occupancy == '0);
  assign front_dec = (front_index == '0) ? TOP_IDX : front_index - 1'b1;
  assign front_inc = (front_index == TOP_IDX) ? '0 : front_index + 1'b1;
  assign rear_sum  = {1'b0, front_index} + (IW + 1)'(occupancy);
  assign rear_addr = (rear_sum >= DEPTH_W) ? IW'(rear_sum - DEPTH_W) : rear_sum[IW-1:0];

  // room in the result buffer, counting a read still in flight
  assign room = ((OUT_CW + 1)'(fifo_count) + (OUT_CW + 1)'(rd_pend))
                < (OUT_CW + 1)'(OUT_DEPTH);

  assign s_axis_tready = (state == ST_IDLE) && !rd_pend && room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // operation decode and pointer updates
  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    occupancy_next   = occupancy;
    rd_addr_next     = rd_addr;
    lst_left_next    = lst_left;
    mem_we           = 1'b0;
    wr_addr          = rear_addr;
    st_push          = 1'b0;
    st_code          = STATUS_OK;
    rd_issue         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            OP_INS_FRONT: begin
              st_push = 1'b1;
              if (is_full) begin
                st_code = STATUS_FULL;
              end else begin
                front_index_next = front_dec;
                wr_addr          = front_dec;
                mem_we           = 1'b1;
                occupancy_next   = occupancy + 1'b1;
              end
            end
            OP_DEL_FRONT: begin
              st_push = 1'b1;
              if (is_empty) begin
                st_code = STATUS_EMPTY;
              end else begin
                front_index_next = (occupancy == CW'(1)) ? '0 : front_inc;
                occupancy_next   = occupancy - 1'b1;
              end
            end
            OP_INS_REAR: begin
              st_push = 1'b1;
              if (is_full) begin
                st_code = STATUS_FULL;
              end else begin
                mem_we         = 1'b1;
                occupancy_next = occupancy + 1'b1;
              end
            end
            OP_DEL_REAR: begin
              st_push = 1'b1;
              if (is_empty) begin
                st_code = STATUS_EMPTY;
              end else begin
                occupancy_next = occupancy - 1'b1;
                if (occupancy == CW'(1)) begin
                  front_index_next = '0;
                end
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                st_push = 1'b1;
                st_code = STATUS_EMPTY;
              end else begin
                state_next    = ST_LIST;
                rd_addr_next  = front_index;
                lst_left_next = occupancy;
              end
            end
            default: begin
              // unused codes are dropped
            end
          endcase
        end
      end
      ST_LIST: begin
        if (room) begin
          rd_issue      = 1'b1;
          lst_left_next = lst_left - 1'b1;
          rd_addr_next  = (rd_addr == TOP_IDX) ? '0 : rd_addr + 1'b1;
          if (lst_left == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      rd_pend     <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      occupancy   <= occupancy_next;
      rd_pend     <= rd_issue;
    end
  end

  // list walk registers
  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    lst_left <= lst_left_next;
    if (rd_issue) begin
      rd_last <= (lst_left == CW'(1));
    end
  end

  // ring store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= s_axis_tdata;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // a status word and a landing read never coincide
  always_comb begin
    push.valid = st_push || rd_pend;
    if (rd_pend) begin
      push.data = '{entry: rd_data, status: STATUS_OK, is_last: rd_last};
    end else begin
      push.data = '{entry: '0, status: st_code, is_last: 1'b1};
    end
  end

  deq_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .count     (fifo_count),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data.entry;
  assign m_axis_tuser = out_data.status;
  assign m_axis_tlast = out_data.is_last;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front_index <= TOP_IDX)
    else $error("front index outside ring");

  a_list_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser == OP_LIST && !is_empty) |=> (state == ST_LIST))
    else $error("list of non-empty queue did not start walk");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !accept)
    else $error("word taken while a list read was in flight");

  a_front_reset_on_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && occupancy == '0) |-> (front_index == '0))
    else $error("empty queue with non-zero front index");
`endif

endmodule
